/* rtl/core/sprg_pkg.sv */
`timescale 1ns / 1ps

package sprg_pkg;

   // sine resolution and rotation count
   localparam int SINE_FRACTION_BITS = 16;
   localparam int CORDIC_ITERATIONS  = 16;
   localparam int CORDIC_STEPS       = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
   localparam int CORDIC_CNT_W       = 5;
   localparam int CORDIC_W           = 34;
   localparam int SINE_SHIFT         = 30 - SINE_FRACTION_BITS;
   localparam int SINE_W             = SINE_FRACTION_BITS + 1;
   localparam int FACTOR_W           = SINE_FRACTION_BITS + 2;
   localparam int MIX_W              = 16 + FACTOR_W;

   localparam logic signed [CORDIC_W-1:0] SINE_LIMIT  = CORDIC_W'(1) << SINE_FRACTION_BITS;
   localparam logic [FACTOR_W-1:0]        FACTOR_BASE = FACTOR_W'(1) << SINE_FRACTION_BITS;

   localparam logic [30:0]                Q30_HALF_PI = 31'd1686629713;
   localparam logic signed [CORDIC_W-1:0] Q30_GAIN    = CORDIC_W'(652032874);

   // restoring divider
   localparam int DIV_ITERS = 31;
   localparam int DIV_QUO_W = 31;
   localparam int DIV_REM_W = 14;
   localparam int DIV_CNT_W = 5;

   // speed map divide by 99: (p * ceil(2^30 / 99)) >> 30, exact for p below 2^23
   localparam logic [23:0] SPEED_RECIP       = 24'd10845878;
   localparam int          SPEED_RECIP_SHIFT = 30;

   // request kinds
   localparam logic [2:0] KIND_POLL      = 3'd0;
   localparam logic [2:0] KIND_COUNTED   = 3'd1;
   localparam logic [2:0] KIND_CONSTANT  = 3'd2;
   localparam logic [2:0] KIND_ENABLE    = 3'd3;
   localparam logic [2:0] KIND_DIRECTION = 3'd4;

   // csr indexes
   localparam logic [1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_MAX_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_RAMP_LIMIT   = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_us;
      logic [14:0] step_count;
      logic [6:0]  speed;
      logic        level;
   } req_type;

   typedef struct packed {
      logic        step_pulse;
      logic        enable_level;
      logic        direction_level;
      logic        moving;
      logic [15:0] interval_us;
   } rsp_type;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [CORDIC_CNT_W-1:0] k);
      logic signed [CORDIC_W-1:0] a;
      unique case (k)
         5'd0:  a = CORDIC_W'(843314857);
         5'd1:  a = CORDIC_W'(497837829);
         5'd2:  a = CORDIC_W'(263043837);
         5'd3:  a = CORDIC_W'(133525159);
         5'd4:  a = CORDIC_W'(67021687);
         5'd5:  a = CORDIC_W'(33543516);
         5'd6:  a = CORDIC_W'(16775851);
         5'd7:  a = CORDIC_W'(8388437);
         5'd8:  a = CORDIC_W'(4194283);
         5'd9:  a = CORDIC_W'(2097149);
         5'd10: a = CORDIC_W'(1048576);
         5'd11: a = CORDIC_W'(524288);
         5'd12: a = CORDIC_W'(262144);
         5'd13: a = CORDIC_W'(131072);
         5'd14: a = CORDIC_W'(65536);
         5'd15: a = CORDIC_W'(32768);
         5'd16: a = CORDIC_W'(16384);
         5'd17: a = CORDIC_W'(8192);
         5'd18: a = CORDIC_W'(4096);
         5'd19: a = CORDIC_W'(2048);
         5'd20: a = CORDIC_W'(1024);
         5'd21: a = CORDIC_W'(512);
         5'd22: a = CORDIC_W'(256);
         5'd23: a = CORDIC_W'(128);
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic [15:0] sat16(input logic signed [19:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 20'sd65535) begin
         r = 16'hFFFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/stepper_pulse_ramp_generator.sv */
`timescale 1ns / 1ps

// Step pulse generator for one stepper axis. Every request transaction carries the
// current microsecond time and is a poll, a counted move, a constant-speed move, an
// enable change or a direction change; each returns exactly one response transaction
// with the pulse flag, the enable/direction/moving levels and the interval now due.
// A pulse is issued when the axis is enabled and moving and at least interval_us has
// passed since the previous pulse, but not on the last step of a move that stops.
// Counted moves ease the interval along a quarter sine over the first and last
// min(ramp_step_limit, count/2) steps; speeds 1..100 map linearly from max_interval_us
// down to min_interval_us. The block handles one request at a time. A pulse inside a
// ramp goes through the bit-serial divider for the rotation angle, then one CORDIC
// rotation per cycle, 16 rotations by default. Starting a move with a speed first
// passes through the speed map.
// Configuration writes are accepted every cycle but are meant for idle periods.
module stepper_pulse_ramp_generator
   import sprg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SPEED,
      ST_DIV,
      ST_DIV_DONE,
      ST_POLL,
      ST_NEXT,
      ST_CORDIC,
      ST_SINE,
      ST_MIX,
      ST_RESP
   } state_type;

   // what the quotient feeds
   typedef enum logic [1:0] {
      DIV_AFTER,
      DIV_CONST,
      DIV_RAMP
   } div_target_type;

   state_type      state_ff;
   div_target_type target_ff;
   req_type        req_ff;

   // configuration
   logic [15:0] min_ff;
   logic [15:0] max_ff;
   logic [13:0] limit_ff;

   // axis state
   logic        enabled_ff;
   logic        moving_ff;
   logic        const_mode_ff;
   logic        dir_ff;
   logic [15:0] steps_rem_ff;
   logic [14:0] steps_total_ff;
   logic [13:0] ramp_steps_ff;
   logic [15:0] after_ff;
   logic [15:0] const_int_ff;
   logic [31:0] last_time_ff;
   logic [15:0] cur_int_ff;
   logic        pulse_ff;

   // divider
   logic [DIV_REM_W-1:0] div_rem_ff;
   logic [DIV_QUO_W-1:0] div_quo_ff;
   logic [DIV_REM_W-1:0] div_den_ff;
   logic                 div_neg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // cordic
   logic signed [CORDIC_W-1:0] x_ff;
   logic signed [CORDIC_W-1:0] y_ff;
   logic signed [CORDIC_W-1:0] z_ff;
   logic [CORDIC_CNT_W-1:0]    cordic_cnt_ff;

   // final interval mix
   logic [MIX_W-1:0] mix_ff;
   logic             mix_neg_ff;

   // speed map operands: (speed-1)*(min-max), sign and magnitude
   logic signed [16:0] spd_diff;
   logic [15:0]        spd_dmag;
   logic [6:0]         spd_mag;
   logic [22:0]        spd_prod;
   logic               spd_neg;
   logic [46:0]        spd_recip;
   logic signed [18:0] spd_q;
   logic signed [19:0] spd_sum;
   logic [15:0]        spd_val;

   // divider step
   logic [DIV_REM_W:0]   div_trial;
   logic [DIV_REM_W:0]   div_sub;
   logic                 div_ge;
   logic [DIV_REM_W-1:0] div_rem_in;

   // poll
   logic [31:0] elapsed;
   logic        due;
   logic [15:0] rem_dec;

   // ramp position
   logic signed [16:0] rem_s;
   logic signed [16:0] done_s;
   logic signed [16:0] i_raw;
   logic signed [16:0] i_pos;
   logic               use_min;
   logic [44:0]        z_prod;

   // cordic rotation
   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] atan_k;

   // sine to interval
   logic signed [CORDIC_W-1:0] y_sh;
   logic [SINE_W-1:0]          sine_val;
   logic [FACTOR_W-1:0]        factor;
   logic signed [16:0]         mix_diff;
   logic [15:0]                mix_dmag;
   logic [MIX_W-1:0]           mix_prod;
   logic [15:0]                q_mag;
   logic signed [17:0]         mix_q;
   logic signed [19:0]         mix_res;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign csr_ready = 1'b1;

   assign rsp_data.step_pulse      = pulse_ff;
   assign rsp_data.enable_level    = enabled_ff;
   assign rsp_data.direction_level = dir_ff;
   assign rsp_data.moving          = moving_ff;
   assign rsp_data.interval_us     = cur_int_ff;

   // speed map, truncating toward zero through sign and magnitude
   assign spd_diff = $signed({1'b0, min_ff}) - $signed({1'b0, max_ff});
   assign spd_dmag = spd_diff[16] ? 16'(-spd_diff) : spd_diff[15:0];
   assign spd_mag  = (req_ff.speed == 7'd0) ? 7'd1 : req_ff.speed - 7'd1;
   assign spd_prod = {16'b0, spd_mag} * {7'b0, spd_dmag};
   assign spd_neg  = (req_ff.speed == 7'd0) ^ spd_diff[16];
   // divide by 99 through the reciprocal
   assign spd_recip = 47'(div_quo_ff[22:0]) * 47'(SPEED_RECIP);
   assign spd_q    = div_neg_ff ? -$signed({2'b0, div_quo_ff[16:0]})
                                :  $signed({2'b0, div_quo_ff[16:0]});
   assign spd_sum  = $signed({4'b0, max_ff}) + $signed({spd_q[18], spd_q});
   assign spd_val  = sat16(spd_sum);

   // one quotient bit per cycle
   assign div_trial  = {div_rem_ff, div_quo_ff[DIV_QUO_W-1]};
   assign div_sub    = div_trial - {1'b0, div_den_ff};
   assign div_ge     = (div_trial >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? div_sub[DIV_REM_W-1:0] : div_trial[DIV_REM_W-1:0];

   assign elapsed = req_ff.now_us - last_time_ff;
   assign due     = (elapsed >= {16'b0, cur_int_ff});
   assign rem_dec = steps_rem_ff - 16'd1;

   // distance to the nearer end of the move
   assign rem_s   = $signed({1'b0, steps_rem_ff});
   assign done_s  = $signed({2'b0, steps_total_ff}) - rem_s;
   assign i_raw   = (rem_s < done_s) ? rem_s : done_s;
   assign i_pos   = i_raw[16] ? 17'sd0 : i_raw;
   assign use_min = (ramp_steps_ff == 14'd0) || (i_pos > $signed({3'b0, ramp_steps_ff}));
   assign z_prod  = {14'b0, Q30_HALF_PI} * {31'b0, i_pos[13:0]};

   assign dx     = y_ff >>> cordic_cnt_ff;
   assign dy     = x_ff >>> cordic_cnt_ff;
   assign atan_k = atan_q30(cordic_cnt_ff);

   // sine clamped to [0, 1] in fraction bits
   assign y_sh = y_ff >>> SINE_SHIFT;
   always_comb begin
      if (y_sh < 0) begin
         sine_val = '0;
      end else if (y_sh > SINE_LIMIT) begin
         sine_val = SINE_LIMIT[SINE_W-1:0];
      end else begin
         sine_val = y_sh[SINE_W-1:0];
      end
   end

   assign factor   = FACTOR_BASE + FACTOR_W'(sine_val);
   assign mix_diff = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
   assign mix_dmag = mix_diff[16] ? 16'(-mix_diff) : mix_diff[15:0];
   assign mix_prod = MIX_W'(mix_dmag) * MIX_W'(factor);
   assign q_mag    = mix_ff[SINE_FRACTION_BITS+16:SINE_FRACTION_BITS+1];
   assign mix_q    = mix_neg_ff ? -$signed({2'b0, q_mag}) : $signed({2'b0, q_mag});
   assign mix_res  = $signed({4'b0, max_ff}) - $signed({{2{mix_q[17]}}, mix_q});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         target_ff      <= DIV_AFTER;
         min_ff         <= 16'd1;
         max_ff         <= 16'd2;
         limit_ff       <= 14'd200;
         enabled_ff     <= 1'b0;
         moving_ff      <= 1'b0;
         const_mode_ff  <= 1'b0;
         dir_ff         <= 1'b0;
         steps_rem_ff   <= '0;
         steps_total_ff <= '0;
         ramp_steps_ff  <= '0;
         after_ff       <= '0;
         const_int_ff   <= '0;
         last_time_ff   <= '0;
         cur_int_ff     <= '0;
         pulse_ff       <= 1'b0;
         div_cnt_ff     <= '0;
         cordic_cnt_ff  <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_INTERVAL: min_ff   <= csr_wdata;
               CSR_MAX_INTERVAL: max_ff   <= csr_wdata;
               CSR_RAMP_LIMIT:   limit_ff <= csr_wdata[13:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  pulse_ff <= 1'b0;
                  state_ff <= ST_DECODE;
               end
            end

            ST_DECODE: begin
               // speed product is loaded in every case, used only for moves
               div_quo_ff <= {8'b0, spd_prod};
               div_neg_ff <= spd_neg;
               unique case (req_ff.kind)
                  KIND_POLL: state_ff <= ST_POLL;
                  KIND_COUNTED: begin
                     if (req_ff.step_count == 15'd0) begin
                        state_ff <= ST_RESP;
                     end else begin
                        steps_rem_ff   <= {1'b0, req_ff.step_count};
                        steps_total_ff <= req_ff.step_count;
                        ramp_steps_ff  <= (limit_ff < req_ff.step_count[14:1]) ?
                                          limit_ff : req_ff.step_count[14:1];
                        const_mode_ff  <= 1'b0;
                        moving_ff      <= 1'b1;
                        last_time_ff   <= '0;
                        if (req_ff.speed == 7'd0) begin
                           after_ff <= '0;
                           state_ff <= ST_POLL;
                        end else begin
                           target_ff <= DIV_AFTER;
                           state_ff  <= ST_SPEED;
                        end
                     end
                  end
                  KIND_CONSTANT: begin
                     const_mode_ff <= 1'b1;
                     moving_ff     <= 1'b1;
                     last_time_ff  <= '0;
                     target_ff     <= DIV_CONST;
                     state_ff      <= ST_SPEED;
                  end
                  KIND_ENABLE: begin
                     enabled_ff <= req_ff.level;
                     state_ff   <= ST_RESP;
                  end
                  KIND_DIRECTION: begin
                     dir_ff   <= req_ff.level;
                     state_ff <= ST_RESP;
                  end
                  default: state_ff <= ST_RESP;
               endcase
            end

            ST_SPEED: begin
               div_quo_ff <= DIV_QUO_W'(spd_recip[46:SPEED_RECIP_SHIFT]);
               state_ff   <= ST_DIV_DONE;
            end

            ST_DIV: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= {div_quo_ff[DIV_QUO_W-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(DIV_ITERS - 1)) begin
                  state_ff <= ST_DIV_DONE;
               end
            end

            ST_DIV_DONE: begin
               unique case (target_ff)
                  DIV_AFTER: begin
                     after_ff <= spd_val;
                     state_ff <= ST_POLL;
                  end
                  DIV_CONST: begin
                     const_int_ff <= spd_val;
                     state_ff     <= ST_POLL;
                  end
                  DIV_RAMP: begin
                     x_ff          <= Q30_GAIN;
                     y_ff          <= '0;
                     z_ff          <= $signed({3'b0, div_quo_ff});
                     cordic_cnt_ff <= '0;
                     state_ff      <= ST_CORDIC;
                  end
                  default: state_ff <= ST_RESP;
               endcase
            end

            ST_POLL: begin
               if (!(enabled_ff && moving_ff) || !due) begin
                  state_ff <= ST_RESP;
               end else if (!const_mode_ff && rem_dec == 16'd0 && after_ff == 16'd0) begin
                  // last step of a move that stops: no pulse
                  steps_rem_ff <= rem_dec;
                  moving_ff    <= 1'b0;
                  state_ff     <= ST_RESP;
               end else begin
                  if (!const_mode_ff) begin
                     steps_rem_ff <= rem_dec;
                     if (rem_dec == 16'd0) begin
                        // move hands over to its continuing speed
                        const_mode_ff <= 1'b1;
                        const_int_ff  <= after_ff;
                     end
                  end
                  pulse_ff     <= 1'b1;
                  last_time_ff <= req_ff.now_us;
                  state_ff     <= ST_NEXT;
               end
            end

            ST_NEXT: begin
               if (const_mode_ff) begin
                  cur_int_ff <= const_int_ff;
                  state_ff   <= ST_RESP;
               end else if (use_min) begin
                  cur_int_ff <= min_ff;
                  state_ff   <= ST_RESP;
               end else begin
                  // angle = half_pi * i / ramp_steps, quotient stays below 2^31
                  div_rem_ff <= z_prod[44:31];
                  div_quo_ff <= z_prod[30:0];
                  div_den_ff <= ramp_steps_ff;
                  div_neg_ff <= 1'b0;
                  div_cnt_ff <= '0;
                  target_ff  <= DIV_RAMP;
                  state_ff   <= ST_DIV;
               end
            end

            ST_CORDIC: begin
               if (!z_ff[CORDIC_W-1]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_k;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_k;
               end
               cordic_cnt_ff <= cordic_cnt_ff + CORDIC_CNT_W'(1);
               if (cordic_cnt_ff == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_SINE;
               end
            end

            ST_SINE: begin
               mix_ff     <= mix_prod;
               mix_neg_ff <= mix_diff[16];
               state_ff   <= ST_MIX;
            end

            ST_MIX: begin
               cur_int_ff <= sat16(mix_res);
               state_ff   <= ST_RESP;
            end

            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // one transaction in flight: never taking a request while a response waits
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request accepted while response pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted before response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("not idle after response delivered");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_pulse |-> rsp_data.moving && rsp_data.enable_level)
      else $error("pulse while stopped or disabled");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC |-> cordic_cnt_ff < CORDIC_CNT_W'(CORDIC_STEPS))
      else $error("cordic rotation count overrun");

endmodule
